[design/kst_pkg.sv]
// Package with types, constants and helpers for the spanning tree block.
`default_nettype none
package kst_pkg;
  localparam int MAX_NODES_DEF   = 64;
  localparam int MAX_EDGES_DEF   = 256;
  localparam int WEIGHT_BITS_DEF = 32;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTED   = 1'd1;

  typedef struct packed {
    logic [5:0]         edge_src;
    logic [5:0]         edge_dst;
    logic signed [31:0] edge_weight;
    logic               edge_last;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         tree_src;
    logic [5:0]         tree_dst;
    logic signed [31:0] tree_weight;
    logic               final_edge;
    logic               tree_empty;
    logic               table_full;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_INS,
    ST_SORT_RD,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_LBL_INIT,
    ST_KR_RD,
    ST_KR_EDGE,
    ST_KR_LB,
    ST_KR_LAB,
    ST_KR_RELAB_RD,
    ST_KR_RELAB_CMP,
    ST_KR_EMIT,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

[design/kst_ram.sv]
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write first is not needed: read returns old content on a write cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[design/kruskal_spanning_tree.sv]
// Top level of the Kruskal minimum spanning tree block.
//
// Edges are loaded one per transaction while busy is low. An edge with both
// ends in range starts a duplicate search over the stored entries through
// the single-ported edge memory, then overwrites a match in place or appends
// the edge (or flags overflow when the table is full); the reverse pair is
// handled the same way when it is also stored. After the edge marked last,
// an insertion sort over the edge memory runs, the labels of all MAX_NODES
// nodes are set to their own index, and Kruskal then reads the two labels of
// each visited edge and relabels the live nodes for each tree edge found.
// Results are strobed on out_valid for one cycle each; the receiver cannot
// stall. For the edge marked last, busy stays high from acceptance until the
// cycle in which the last result is on the output ports.
`default_nettype none
module kruskal_spanning_tree #(
  parameter int MAX_EDGES   = kst_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = kst_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire kst_pkg::in_item_t               in_item,
  output logic                                 out_valid,
  output kst_pkg::out_item_t                   out_item,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [kst_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  // Node indices are six bits wide on the ports, so the node capacity is fixed.
  localparam int MAX_NODES = kst_pkg::MAX_NODES_DEF;
  localparam int NB  = $clog2(MAX_NODES);
  localparam int EB  = $clog2(MAX_EDGES);
  localparam int CB  = EB + 1;
  localparam int WB  = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
  localparam int EW  = 12 + WB;
  localparam int NCB = NB + 1;

  typedef struct packed {
    logic [5:0]           src;
    logic [5:0]           dst;
    logic signed [WB-1:0] wt;
  } rec_t;

  kst_pkg::state_t st_r, st_nxt;

  logic [6:0] node_count_r;
  logic       directed_r;
  logic [CB-1:0] cnt_r, cnt_nxt;
  logic       ovf_r, ovf_nxt;
  logic [CB-1:0] i_r, i_nxt, j_r, j_nxt;
  rec_t       key_r, key_nxt;
  logic       rev_r, rev_nxt;
  logic       last_r, last_nxt;
  logic [NB:0] k_r, k_nxt;
  logic [NB-1:0] la_r, la_nxt, lb_r, lb_nxt;
  logic [5:0] tcnt_r, tcnt_nxt;
  logic       full_r, full_nxt;

  // Edge memory and label memory.
  logic          e_we;
  logic [EB-1:0] e_addr;
  rec_t          e_wdata, e_rdata;
  logic          l_we;
  logic [NB-1:0] l_addr;
  logic [NB-1:0] l_wdata, l_rdata;

  kst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
  );
  kst_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_label_ram (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
  );

  // Live node count, clamped to the node capacity.
  logic [NCB-1:0] n_live;
  always_comb begin
    if ({25'd0, node_count_r} > MAX_NODES) begin
      n_live = NCB'(MAX_NODES);
    end else begin
      n_live = NCB'(node_count_r);
    end
  end
  logic [NCB-1:0] limit;
  assign limit = (n_live != '0) ? n_live - 1'b1 : '0;

  function automatic logic first_of(rec_t a, rec_t b);
    if (a.wt != b.wt) return a.wt < b.wt;
    if (a.src != b.src) return a.src < b.src;
    return a.dst < b.dst;
  endfunction

  logic in_ok;
  assign in_ok = ({{(NCB-6){1'b0}}, in_item.edge_src} < n_live) &&
                 ({{(NCB-6){1'b0}}, in_item.edge_dst} < n_live);

  // Kruskal edge range check against the live node count.
  logic e_ok;
  assign e_ok = ({{(NCB-6){1'b0}}, e_rdata.src} < n_live) &&
                ({{(NCB-6){1'b0}}, e_rdata.dst} < n_live);

  assign cfg_ready = (st_r == kst_pkg::ST_IDLE);
  assign busy      = (st_r != kst_pkg::ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 7'd64;
      directed_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kst_pkg::REG_NODE_COUNT: node_count_r <= cfg_data[6:0];
        kst_pkg::REG_DIRECTED:   directed_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r; ovf_nxt = ovf_r; i_nxt = i_r; j_nxt = j_r;
    key_nxt = key_r; rev_nxt = rev_r; last_nxt = last_r; k_nxt = k_r;
    la_nxt = la_r; tcnt_nxt = tcnt_r; full_nxt = full_r;
    case (st_r)
      kst_pkg::ST_IDLE: begin
        if (start) begin
          key_nxt.src = in_item.edge_src;
          key_nxt.dst = in_item.edge_dst;
          key_nxt.wt  = in_item.edge_weight[WB-1:0];
          last_nxt = in_item.edge_last;
          rev_nxt  = 1'b0;
          i_nxt    = '0;
          if (in_ok) st_nxt = kst_pkg::ST_SRCH_RD;
          else if (in_item.edge_last) begin
            i_nxt = CB'(1); st_nxt = kst_pkg::ST_SORT_RD;
          end else st_nxt = kst_pkg::ST_DONE;
        end
      end
      kst_pkg::ST_SRCH_RD: begin
        if (i_r >= cnt_r) st_nxt = kst_pkg::ST_INS;
        else st_nxt = kst_pkg::ST_SRCH_CMP;
      end
      kst_pkg::ST_SRCH_CMP, kst_pkg::ST_INS: begin
        // Match overwrites in place; otherwise append or flag overflow.
        if (st_r == kst_pkg::ST_SRCH_CMP &&
            !(e_rdata.src == key_r.src && e_rdata.dst == key_r.dst)) begin
          i_nxt = i_r + 1'b1;
          st_nxt = kst_pkg::ST_SRCH_RD;
        end else begin
          if (st_r == kst_pkg::ST_INS) begin
            if (cnt_r < CB'(MAX_EDGES)) cnt_nxt = cnt_r + 1'b1;
            else ovf_nxt = 1'b1;
          end
          if (!rev_r && !directed_r && key_r.src != key_r.dst) begin
            rev_nxt = 1'b1;
            key_nxt.src = key_r.dst;
            key_nxt.dst = key_r.src;
            i_nxt = '0;
            st_nxt = kst_pkg::ST_SRCH_RD;
          end else if (last_r) begin
            i_nxt = CB'(1);
            st_nxt = kst_pkg::ST_SORT_RD;
          end else st_nxt = kst_pkg::ST_DONE;
        end
      end
      // Insertion sort: key = entry i, shift larger entries up.
      kst_pkg::ST_SORT_RD: begin
        if (i_r >= cnt_r) begin
          k_nxt = '0; st_nxt = kst_pkg::ST_LBL_INIT;
        end else st_nxt = kst_pkg::ST_SORT_KEY;
      end
      kst_pkg::ST_SORT_KEY: begin
        key_nxt = e_rdata;
        j_nxt = i_r;
        st_nxt = kst_pkg::ST_SORT_CMP;
      end
      kst_pkg::ST_SORT_CMP: st_nxt = kst_pkg::ST_SORT_PUT;
      kst_pkg::ST_SORT_PUT: begin
        if (j_r != '0 && first_of(key_r, e_rdata)) begin
          j_nxt = j_r - 1'b1;
          st_nxt = kst_pkg::ST_SORT_CMP;
        end else begin
          i_nxt = i_r + 1'b1;
          st_nxt = kst_pkg::ST_SORT_RD;
        end
      end
      kst_pkg::ST_LBL_INIT: begin
        if (k_r == (NB+1)'(MAX_NODES - 1)) begin
          i_nxt = '0; tcnt_nxt = '0; full_nxt = ovf_r;
          st_nxt = kst_pkg::ST_KR_RD;
        end
        k_nxt = k_r + 1'b1;
      end
      kst_pkg::ST_KR_RD: begin
        if (i_r >= cnt_r || {{(NCB-6){1'b0}}, tcnt_r} >= limit)
          st_nxt = kst_pkg::ST_KR_EMIT;
        else st_nxt = kst_pkg::ST_KR_EDGE;
      end
      kst_pkg::ST_KR_EDGE: begin
        key_nxt = e_rdata;
        if (e_ok) st_nxt = kst_pkg::ST_KR_LB;
        else begin
          i_nxt = i_r + 1'b1; st_nxt = kst_pkg::ST_KR_RD;
        end
      end
      kst_pkg::ST_KR_LB: st_nxt = kst_pkg::ST_KR_LAB;
      kst_pkg::ST_KR_LAB: begin
        // Label of src is in rdata; label of dst was latched last cycle.
        la_nxt = l_rdata;
        if (l_rdata == lb_r) begin
          i_nxt = i_r + 1'b1; st_nxt = kst_pkg::ST_KR_RD;
        end else begin
          k_nxt = '0; st_nxt = kst_pkg::ST_KR_RELAB_RD;
        end
      end
      kst_pkg::ST_KR_RELAB_RD: begin
        if (k_r >= (NB+1)'(n_live)) begin
          tcnt_nxt = tcnt_r + 1'b1;
          st_nxt = kst_pkg::ST_KR_EMIT;
        end else st_nxt = kst_pkg::ST_KR_RELAB_CMP;
      end
      kst_pkg::ST_KR_RELAB_CMP: begin
        k_nxt = k_r + 1'b1;
        st_nxt = kst_pkg::ST_KR_RELAB_RD;
      end
      kst_pkg::ST_KR_EMIT: begin
        // Entered with a found edge (tree edge) or at the end of the scan.
        if (i_r >= cnt_r || {{(NCB-6){1'b0}}, tcnt_r} >= limit) begin
          cnt_nxt = '0; ovf_nxt = 1'b0;
          st_nxt = kst_pkg::ST_IDLE;
        end else st_nxt = kst_pkg::ST_KR_RD;
        i_nxt = i_r + 1'b1;
      end
      kst_pkg::ST_DONE: st_nxt = kst_pkg::ST_IDLE;
      default: st_nxt = kst_pkg::ST_IDLE;
    endcase
  end

  // Pending tree edge waiting to be shown: one edge is held in pk_r and
  // flushed at the next emit so final_edge can be marked on the last one.
  logic pend_r, pend_nxt;
  rec_t pk_r, pk_nxt;
  logic emit_edge, emit_end;
  assign emit_edge = (st_r == kst_pkg::ST_KR_RELAB_RD) && (k_r >= (NB+1)'(n_live));
  assign emit_end  = (st_r == kst_pkg::ST_KR_EMIT) &&
                     (i_r >= cnt_r || {{(NCB-6){1'b0}}, tcnt_r} >= limit);

  always_comb begin
    pend_nxt = pend_r;
    pk_nxt   = pk_r;
    if (st_r == kst_pkg::ST_LBL_INIT) pend_nxt = 1'b0;
    if (emit_edge) begin
      pend_nxt = 1'b1; pk_nxt = key_r;
    end
    if (emit_end) pend_nxt = 1'b0;
  end

  // Output strobe: previous pending edge is shown when a new one arrives,
  // and the last one (or the empty marker) at the end of the scan.
  logic      ov_nxt;
  kst_pkg::out_item_t oi_nxt;
  always_comb begin
    ov_nxt = 1'b0;
    oi_nxt = '0;
    oi_nxt.table_full = full_r;
    if (emit_edge && pend_r) begin
      ov_nxt = 1'b1;
      oi_nxt.tree_src = pk_r.src;
      oi_nxt.tree_dst = pk_r.dst;
      oi_nxt.tree_weight = 32'(signed'(pk_r.wt));
    end else if (emit_end) begin
      ov_nxt = 1'b1;
      oi_nxt.final_edge = 1'b1;
      if (pend_r) begin
        oi_nxt.tree_src = pk_r.src;
        oi_nxt.tree_dst = pk_r.dst;
        oi_nxt.tree_weight = 32'(signed'(pk_r.wt));
      end else oi_nxt.tree_empty = 1'b1;
    end
  end

  // Memory port control.
  always_comb begin
    e_we = 1'b0; e_addr = i_r[EB-1:0]; e_wdata = key_r;
    l_we = 1'b0; l_addr = key_r.src[NB-1:0]; l_wdata = la_r;
    case (st_r)
      kst_pkg::ST_SRCH_CMP: begin
        if (e_rdata.src == key_r.src && e_rdata.dst == key_r.dst) e_we = 1'b1;
      end
      kst_pkg::ST_INS: begin
        e_addr = cnt_r[EB-1:0];
        e_we = (cnt_r < CB'(MAX_EDGES));
      end
      kst_pkg::ST_SORT_CMP: e_addr = j_r[EB-1:0] - 1'b1;
      kst_pkg::ST_SORT_PUT: begin
        e_addr = j_r[EB-1:0];
        e_we = 1'b1;
        if (j_r != '0 && first_of(key_r, e_rdata)) e_wdata = e_rdata;
      end
      kst_pkg::ST_LBL_INIT: begin
        l_we = 1'b1; l_addr = k_r[NB-1:0]; l_wdata = k_r[NB-1:0];
      end
      kst_pkg::ST_KR_EDGE: l_addr = e_rdata.dst[NB-1:0];
      kst_pkg::ST_KR_LB:   l_addr = key_r.src[NB-1:0];
      kst_pkg::ST_KR_RELAB_RD: l_addr = k_r[NB-1:0];
      kst_pkg::ST_KR_RELAB_CMP: begin
        l_addr = k_r[NB-1:0];
        l_we = (l_rdata == lb_r);
      end
      default: ;
    endcase
  end

  // The dst label arrives in ST_KR_LB.
  always_comb begin
    lb_nxt = lb_r;
    if (st_r == kst_pkg::ST_KR_LB) lb_nxt = l_rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= kst_pkg::ST_IDLE;
      cnt_r <= '0; ovf_r <= 1'b0; pend_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; pend_r <= pend_nxt;
      out_valid <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; key_r <= key_nxt; rev_r <= rev_nxt;
    last_r <= last_nxt; k_r <= k_nxt; la_r <= la_nxt; lb_r <= lb_nxt;
    tcnt_r <= tcnt_nxt; full_r <= full_nxt;
    pk_r <= pk_nxt; out_item <= oi_nxt;
  end

  // Checks on the sequencer.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CB'(MAX_EDGES)) else $error("edge count beyond capacity");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction not started");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_end) |=> (out_valid && out_item.final_edge && !busy))
    else $error("run end not reported");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cfg_ready) else $error("config taken while busy");
endmodule
`default_nettype wire

[tb/sv/tb_kruskal_spanning_tree.sv]
// Self-checking testbench for the Kruskal minimum spanning tree block.
`timescale 1ns / 1ps
module tb_kruskal_spanning_tree;

  typedef struct {
    logic [5:0]         src;
    logic [5:0]         dst;
    logic signed [31:0] wt;
  } graph_edge_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  kst_pkg::in_item_t    in_item = '0;
  logic                 out_valid;
  kst_pkg::out_item_t   out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [kst_pkg::CFG_IDX_BITS-1:0] cfg_index = kst_pkg::REG_NODE_COUNT;
  logic [31:0]          cfg_data = '0;

  kruskal_spanning_tree dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pending edges, expected tree edges and the mirrored block state.
  kst_pkg::in_item_t  edge_feed_q[$];
  kst_pkg::out_item_t tree_expect_q[$];
  graph_edge_t edge_table[kst_pkg::MAX_EDGES_DEF];
  int          edge_total;
  bit          dropped_edge;
  logic [6:0]  node_limit = 7'd64;
  logic        one_way = 1'b0;
  int          errors = 0;
  int          next_gap = 0;
  int          gap_left = 0;
  bit          burst_mode = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int draw_gap();
    if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
    return burst_mode ? 0 : $urandom_range(0, 12);
  endfunction

  // Store a pair, overwriting the weight of an existing one.
  function automatic void store_pair(input logic [5:0] s, input logic [5:0] d,
                                     input logic signed [31:0] w);
    for (int i = 0; i < edge_total; i++) begin
      if (edge_table[i].src == s && edge_table[i].dst == d) begin
        edge_table[i].wt = w;
        return;
      end
    end
    if (edge_total < kst_pkg::MAX_EDGES_DEF) begin
      edge_table[edge_total] = '{s, d, w};
      edge_total++;
    end else begin
      dropped_edge = 1'b1;
    end
  endfunction

  function automatic bit ranks_ahead(input graph_edge_t a, input graph_edge_t b);
    if (a.wt != b.wt) return a.wt < b.wt;
    if (a.src != b.src) return a.src < b.src;
    return a.dst < b.dst;
  endfunction

  // Load one edge; on the last edge sort and pick the spanning tree edges.
  function automatic void predict_tree(input kst_pkg::in_item_t it);
    int                 n, limit, picked, j, la, lb;
    int                 label[kst_pkg::MAX_NODES_DEF];
    graph_edge_t        key;
    kst_pkg::out_item_t res;
    n = (node_limit > kst_pkg::MAX_NODES_DEF) ? kst_pkg::MAX_NODES_DEF
                                              : int'(node_limit);
    if (it.edge_src < n && it.edge_dst < n) begin
      store_pair(it.edge_src, it.edge_dst, it.edge_weight);
      if (!one_way) store_pair(it.edge_dst, it.edge_src, it.edge_weight);
    end
    if (!it.edge_last) return;
    for (int i = 1; i < edge_total; i++) begin
      key = edge_table[i];
      j = i;
      while (j > 0 && ranks_ahead(key, edge_table[j-1])) begin
        edge_table[j] = edge_table[j-1];
        j--;
      end
      edge_table[j] = key;
    end
    for (int i = 0; i < kst_pkg::MAX_NODES_DEF; i++) label[i] = i;
    limit = (n > 0) ? n - 1 : 0;
    picked = 0;
    for (int i = 0; i < edge_total && picked < limit; i++) begin
      if (edge_table[i].src >= n || edge_table[i].dst >= n) continue;
      la = label[edge_table[i].src];
      lb = label[edge_table[i].dst];
      if (la == lb) continue;
      for (int k = 0; k < n; k++) if (label[k] == lb) label[k] = la;
      res = '0;
      res.tree_src = edge_table[i].src;
      res.tree_dst = edge_table[i].dst;
      res.tree_weight = edge_table[i].wt;
      res.final_edge = (picked + 1 == limit);
      res.table_full = dropped_edge;
      tree_expect_q.insert(tree_expect_q.size(), res);
      picked++;
    end
    if (picked == 0) begin
      res = '0;
      res.final_edge = 1'b1;
      res.tree_empty = 1'b1;
      res.table_full = dropped_edge;
      tree_expect_q.insert(tree_expect_q.size(), res);
    end else begin
      // The last tree edge may come before limit when the graph is split.
      tree_expect_q[tree_expect_q.size() - 1].final_edge = 1'b1;
    end
    edge_total = 0;
    dropped_edge = 1'b0;
  endfunction

  // Edge driver: one transaction per queued edge, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && busy) begin
    end else if (start) begin
      if (edge_feed_q.size() > 0 && next_gap == 0) begin
        in_item <= edge_feed_q.pop_front();
        next_gap = draw_gap();
      end else begin
        start <= 1'b0;
        gap_left <= next_gap;
      end
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
    end else if (edge_feed_q.size() > 0) begin
      start <= 1'b1;
      in_item <= edge_feed_q.pop_front();
      next_gap = draw_gap();
    end
  end

  // Mirror accepted transactions and check every result strobe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == kst_pkg::REG_NODE_COUNT) node_limit = cfg_data[6:0];
        else if (cfg_index == kst_pkg::REG_DIRECTED) one_way = cfg_data[0];
      end
      if (start && !busy) predict_tree(in_item);
      if (out_valid) begin
        if (tree_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", out_item));
        end else begin
          kst_pkg::out_item_t want;
          want = tree_expect_q.pop_front();
          if (out_item.tree_src !== want.tree_src)
            report_mismatch($sformatf("tree_src %0d, want %0d",
                                      out_item.tree_src, want.tree_src));
          if (out_item.tree_dst !== want.tree_dst)
            report_mismatch($sformatf("tree_dst %0d, want %0d",
                                      out_item.tree_dst, want.tree_dst));
          if (out_item.tree_weight !== want.tree_weight)
            report_mismatch($sformatf("tree_weight %h, want %h",
                                      out_item.tree_weight, want.tree_weight));
          if (out_item.final_edge !== want.final_edge)
            report_mismatch($sformatf("final_edge %b, want %b",
                                      out_item.final_edge, want.final_edge));
          if (out_item.tree_empty !== want.tree_empty)
            report_mismatch($sformatf("tree_empty %b, want %b",
                                      out_item.tree_empty, want.tree_empty));
          if (out_item.table_full !== want.table_full)
            report_mismatch($sformatf("table_full %b, want %b",
                                      out_item.table_full, want.table_full));
        end
      end
    end
  end

  task automatic wait_idle();
    do begin
      do @(posedge clk);
      while (edge_feed_q.size() > 0 || start || busy || tree_expect_q.size() > 0);
      repeat (8) @(posedge clk);
    end while (busy || start);
  endtask

  task automatic write_reg(input logic [kst_pkg::CFG_IDX_BITS-1:0] idx,
                           input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(input int nodes, input bit dir);
    wait_idle();
    write_reg(kst_pkg::REG_NODE_COUNT, nodes);
    write_reg(kst_pkg::REG_DIRECTED, dir);
  endtask

  task automatic add_edge(input int s, input int d, input logic [31:0] w,
                          input bit last);
    kst_pkg::in_item_t it;
    it.edge_src = 6'(s);
    it.edge_dst = 6'(d);
    it.edge_weight = w;
    it.edge_last = last;
    edge_feed_q.insert(edge_feed_q.size(), it);
  endtask

  initial begin
    int nodes, len, a, b, sent;
    logic [31:0] w;
    bit dir;
    edge_total = 0;
    dropped_edge = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: extreme weights, overwrite, self loop.
    add_edge(0, 63, 32'h7FFF_FFFF, 0);
    add_edge(63, 0, 32'h8000_0000, 0);
    add_edge(5, 5, 32'hFFFF_FFFF, 0);
    add_edge(1, 2, 32'h0, 0);
    add_edge(2, 1, 32'h0, 0);
    add_edge(0, 1, 32'h5, 1);

    // Few nodes; endpoints out of range are ignored, even on the last edge.
    setup(4, 0);
    add_edge(0, 1, 32'h1_0000, 0);
    add_edge(2, 3, 32'h1_0000, 0);
    add_edge(3, 5, 32'h1, 0);
    add_edge(5, 0, 32'h1, 1);
    add_edge(7, 7, 32'h2, 1);

    // Zero nodes and one node give an empty tree.
    setup(0, 0);
    add_edge(0, 0, 32'h3, 1);
    setup(1, 1);
    add_edge(0, 0, 32'h4, 1);

    // Node count above the maximum, one-way edges.
    setup(100, 1);
    add_edge(63, 0, 32'h10, 0);
    add_edge(0, 63, 32'h10, 0);
    add_edge(10, 20, 32'hFFFF_0000, 1);

    // Node count lowered during a load: stored edges beyond it are skipped.
    setup(64, 0);
    add_edge(40, 41, 32'h1, 0);
    add_edge(3, 4, 32'h2, 0);
    wait_idle();
    write_reg(kst_pkg::REG_NODE_COUNT, 8);
    add_edge(1, 2, 32'h7, 1);

    // Table overflow: distinct undirected pairs just past the table size,
    // then an overwrite of a stored pair while the table is full.
    setup(64, 0);
    sent = 0;
    for (int i = 0; i < 64 && sent < 129; i++)
      for (int j = i + 1; j < 64 && sent < 129; j += 7) begin
        w = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 7);
        add_edge(i, j, w, 0);
        sent++;
      end
    add_edge(0, 1, 32'h0, 1);

    // Random graphs, mostly small, with frequent weight ties.
    sent = 0;
    while (sent < 12) begin
      case ($urandom_range(0, 9))
        0: nodes = 64;
        1: nodes = $urandom_range(0, 127);
        default: nodes = $urandom_range(2, 12);
      endcase
      dir = $urandom_range(0, 1);
      setup(nodes, dir);
      len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        if (nodes > 0 && $urandom_range(0, 9) != 0) begin
          a = $urandom_range(0, (nodes > 64 ? 64 : nodes) - 1);
          b = $urandom_range(0, (nodes > 64 ? 64 : nodes) - 1);
        end else begin
          a = $urandom_range(0, 63);
          b = $urandom_range(0, 63);
        end
        w = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 3);
        add_edge(a, b, w, k == len - 1);
        sent++;
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("kruskal_spanning_tree regression: pass");
    else
      $display("kruskal_spanning_tree regression: fail");
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #20ms;
    $display("kruskal_spanning_tree regression: fail");
    $finish;
  end
endmodule
